// File: rtl/core/srwt_pkg.sv
// Shared types and codes for the selective repeat window tracker.
package srwt_pkg;

  typedef enum logic [0:0] {
    CMD_REPORT = 1'b0,
    CMD_ROUND  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OUTC_SUCCESS  = 2'd0,
    OUTC_LOST     = 2'd1,
    OUTC_ACK_LOST = 2'd2,
    OUTC_SPARE    = 2'd3
  } outcome_e;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE  = 1'b0,
    REG_TOTAL_FRAMES = 1'b1
  } reg_idx_e;

  localparam logic [7:0] WINDOW_SIZE_RST  = 8'd4;
  localparam logic [7:0] TOTAL_FRAMES_RST = 8'd16;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the input request
    logic exec;        // check configuration, apply a report
    logic step;        // one chunk step of the bitmap walk
    logic step_deliv;  // walk the receive map instead of the ack map
    logic load_out;    // load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_round;
    logic cfg_bad;
    logic walk_last;
    logic out_free;
  } status_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic       config_error;
    logic       all_done;
    logic [7:0] newly_delivered;
    logic [7:0] delivered_count;
    logic [7:0] window_end;
    logic [7:0] window_base;
    logic       accepted;
  } result_t;

endpackage

// File: rtl/core/srwt_ctrl.sv
// Sequencing state machine for the window tracker.
module srwt_ctrl
  import srwt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_WALK_B = 5'b00100,
    ST_WALK_D = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (status_i.cfg_bad || !status_i.is_round) state_d = ST_EMIT;
        else state_d = ST_WALK_B;
      end
      ST_WALK_B: begin
        cmd_o.step = 1'b1;
        if (status_i.walk_last) state_d = ST_WALK_D;
      end
      ST_WALK_D: begin
        cmd_o.step       = 1'b1;
        cmd_o.step_deliv = 1'b1;
        if (status_i.walk_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the result register is free
        cmd_o.load_out = status_i.out_free;
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/srwt_dpath.sv
// Bitmaps, pointers, chunk walker and result register of the window tracker.
module srwt_dpath
  import srwt_pkg::*;
#(
  parameter int MAX_SEQ = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_cmd_i,
  input  logic [6:0] in_frame_i,
  input  logic [1:0] in_outcome_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output result_t    out_data_o
);

  localparam int IDX_W = ($clog2(MAX_SEQ) > 4) ? $clog2(MAX_SEQ) : 4;
  localparam int MAP_W = 2 ** IDX_W;
  localparam int CI_W  = IDX_W - 3;
  localparam int FW    = (IDX_W > 7) ? IDX_W : 7;
  localparam int PW    = (IDX_W > 8) ? IDX_W : 8;

  logic [7:0]       ws_q, tf_q;
  logic [MAP_W-1:0] ack_q, ack_d, recv_q, recv_d;
  logic [7:0]       base_q, base_d, deliv_q, deliv_d;
  logic             cmd_q;
  logic [6:0]       frame_q;
  logic [1:0]       outcome_q;
  logic [7:0]       dstart_q;
  logic             acc_q, acc_d, err_q, err_d;
  logic             out_valid_q;
  result_t          out_q;

  // configuration check and window end
  logic       cfg_bad;
  logic [8:0] wsum;
  logic [7:0] wend;

  assign cfg_bad = (ws_q == 8'd0) || (tf_q == 8'd0) || (ws_q > tf_q) ||
                   (int'(tf_q) > MAX_SEQ);

  always_comb begin
    wsum = {1'b0, base_q} + {1'b0, ws_q};
    wend = (wsum > {1'b0, tf_q}) ? tf_q : wsum[7:0];
    if (wend < base_q) wend = base_q;
  end

  // report check
  logic [FW-1:0]    frame_ext;
  logic [IDX_W-1:0] fidx;
  logic             hit;

  assign frame_ext = FW'(frame_q);
  assign fidx      = frame_ext[IDX_W-1:0];
  assign hit = ({1'b0, frame_q} >= base_q) && ({1'b0, frame_q} < wend) && !ack_q[fidx];

  // chunk walker, shared by the base slide and the delivery walk
  logic [7:0]       wptr;
  logic [MAP_W-1:0] wmap;
  logic [PW-1:0]    pext;
  logic [CI_W-1:0]  ci;
  logic [7:0]       chunk, bits;
  logic [3:0]       first_zero;
  logic [8:0]       cand;
  logic [7:0]       walk_new;
  logic             walk_last;

  assign wptr  = cmd_i.step_deliv ? deliv_q : base_q;
  assign wmap  = cmd_i.step_deliv ? recv_q : ack_q;
  assign pext  = PW'(wptr);
  assign ci    = pext[IDX_W-1:3];
  assign chunk = wmap[{ci, 3'b000} +: 8];

  always_comb begin
    // treat bits below the pointer as set
    for (int k = 0; k < 8; k++) begin
      bits[k] = chunk[k] | (3'(k) < wptr[2:0]);
    end
    first_zero = 4'd8;
    for (int k = 7; k >= 0; k--) begin
      if (!bits[k]) first_zero = 4'(k);
    end
    cand = {1'b0, wptr[7:3], 3'b000} + {5'b0, first_zero};
    if (wptr >= tf_q) begin
      walk_new  = wptr;
      walk_last = 1'b1;
    end else begin
      walk_new  = (cand > {1'b0, tf_q}) ? tf_q : cand[7:0];
      walk_last = (first_zero != 4'd8) || (cand >= {1'b0, tf_q});
    end
  end

  // next state
  always_comb begin
    ack_d   = ack_q;
    recv_d  = recv_q;
    base_d  = base_q;
    deliv_d = deliv_q;
    acc_d   = acc_q;
    err_d   = err_q;
    if (cmd_i.exec) begin
      err_d = cfg_bad;
      acc_d = !cfg_bad && (cmd_q == CMD_REPORT) && hit;
      if (!cfg_bad && (cmd_q == CMD_REPORT) && hit) begin
        case (outcome_q)
          OUTC_SUCCESS: begin
            ack_d[fidx]  = 1'b1;
            recv_d[fidx] = 1'b1;
          end
          OUTC_ACK_LOST: recv_d[fidx] = 1'b1;
          default: ;
        endcase
      end
    end
    if (cmd_i.step) begin
      if (cmd_i.step_deliv) deliv_d = walk_new;
      else base_d = walk_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q    <= WINDOW_SIZE_RST;
      tf_q    <= TOTAL_FRAMES_RST;
      ack_q   <= '0;
      recv_q  <= '0;
      base_q  <= '0;
      deliv_q <= '0;
      acc_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_SIZE:  ws_q <= cfg_wdata_i;
          REG_TOTAL_FRAMES: tf_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      ack_q   <= ack_d;
      recv_q  <= recv_d;
      base_q  <= base_d;
      deliv_q <= deliv_d;
      acc_q   <= acc_d;
      err_q   <= err_d;
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q     <= in_cmd_i;
      frame_q   <= in_frame_i;
      outcome_q <= in_outcome_i;
      dstart_q  <= deliv_q;
    end
  end

  // result register
  result_t res;

  always_comb begin
    res.accepted        = acc_q;
    res.window_base     = base_q;
    res.window_end      = err_q ? base_q : wend;
    res.delivered_count = deliv_q;
    res.newly_delivered = deliv_q - dstart_q;
    res.all_done        = !err_q && (base_q >= tf_q);
    res.config_error    = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= res;
  end

  assign status_o.is_round  = (cmd_q == CMD_ROUND);
  assign status_o.cfg_bad   = cfg_bad;
  assign status_o.walk_last = walk_last;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/core/selective_repeat_window_tracker_core.sv
// Top level of the selective repeat ARQ window tracker.
//
//  channel   direction  payload
//  s_axis    in         tuser: cmd; tdata: frame_index, outcome
//  m_axis    out        tdata: accepted .. config_error (35 bits in 40)
//  cfg       in         cfg_we_i, cfg_index_i, cfg_wdata_i (8 bits)
//
// A report is captured in the idle state and goes through the execute state
// to the emit state; an end of round also steps the base slide and then the
// delivery walk over the 8-frame bitmap chunks (one chunk per cycle on the
// shared walker, at least one each). The emit state waits for the output
// register; a new request is taken once the result is handed to it, and it
// holds the result while m_axis_tready is low.
// Reset clears both bitmaps and pointers at once; no clearing pass.
module selective_repeat_window_tracker_core
  import srwt_pkg::*;
#(
  parameter int MAX_SEQ = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // frame_index[6:0], outcome[8:7], zero pad
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // accepted[0], window_base[8:1],
                                      // window_end[16:9], delivered_count[24:17],
                                      // newly_delivered[32:25], all_done[33],
                                      // config_error[34], zero pad
);

  cmd_t    cmd;
  status_t status;
  result_t res;

  srwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  srwt_dpath #(
    .MAX_SEQ (MAX_SEQ)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (s_axis_tuser),
    .in_frame_i   (s_axis_tdata[6:0]),
    .in_outcome_i (s_axis_tdata[8:7]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (res)
  );

  assign m_axis_tdata = {5'b0, res};

endmodule

// File: verif/selective_repeat_window_tracker_core_tb.sv
// Self-checking testbench for the selective repeat ARQ window tracker core.
`timescale 1ns / 100ps

module selective_repeat_window_tracker_core_tb;
  import srwt_pkg::*;

  localparam int MAX_SEQ       = 128;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 48;      // settle time, long enough for a round that walks every chunk
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_AT_A     = 300;
  localparam int HOLD_AT_B     = 1400;
  localparam int MAX_REPORTS   = 50;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct {
    cmd_e       cmd;
    logic [6:0] frame;
    outcome_e   outc;
  } frame_req_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [0:0]  cfg_index_i   = REG_WINDOW_SIZE;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // frame_index[6:0], outcome[8:7], zero pad
  logic        s_axis_tuser  = 1'b0; // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // accepted[0], window_base[8:1], window_end[16:9],
                                     // delivered_count[24:17], newly_delivered[32:25],
                                     // all_done[33], config_error[34], zero pad

  selective_repeat_window_tracker_core #(
    .MAX_SEQ(MAX_SEQ)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Window tracking state kept on the testbench side
  bit         ack_bits  [MAX_SEQ];
  bit         recv_bits [MAX_SEQ];
  int         base_q    = 0;
  int         deliver_q = 0;
  logic [7:0] win_cfg   = WINDOW_SIZE_RST;
  logic [7:0] tot_cfg   = TOTAL_FRAMES_RST;

  frame_req_t pend_q [$];
  result_t    window_results_q [$];

  int fail_count    = 0;
  int n_requests    = 0;
  int n_rounds      = 0;
  int n_accepted    = 0;
  int n_cfg_err     = 0;
  int n_done        = 0;
  int results_seen  = 0;
  int cycle_count   = 0;

  // Driver state
  int         burst_left = 1;
  int         gap_left   = 0;
  frame_req_t drv_req;
  result_t    drv_res;

  // Receiver state
  int hold_left    = 0;
  int rx_mode      = 0;
  int rx_phase_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit cfg_invalid();
    return win_cfg == 0 || tot_cfg == 0 || win_cfg > tot_cfg || tot_cfg > MAX_SEQ;
  endfunction

  function automatic int window_end_now();
    int e;
    e = base_q + int'(win_cfg);
    if (e > int'(tot_cfg)) e = int'(tot_cfg);
    if (e < base_q) e = base_q;
    return e;
  endfunction

  // Apply one request to the tracked window and return the result it must produce
  function automatic result_t track_window(cmd_e cmd, logic [6:0] frame, outcome_e outc);
    result_t res;
    int      newly;
    int      fr;
    res   = '0;
    newly = 0;
    fr    = int'(frame);
    if (cfg_invalid()) begin
      res.window_base     = 8'(base_q);
      res.window_end      = 8'(base_q);
      res.delivered_count = 8'(deliver_q);
      res.config_error    = 1'b1;
      return res;
    end
    if (cmd == CMD_REPORT) begin
      if (fr >= base_q && fr < window_end_now() && !ack_bits[fr]) begin
        res.accepted = 1'b1;
        if (outc == OUTC_SUCCESS) begin
          recv_bits[fr] = 1'b1;
          ack_bits[fr]  = 1'b1;
        end else if (outc == OUTC_ACK_LOST) begin
          recv_bits[fr] = 1'b1;
        end
      end
    end else begin
      while (base_q < int'(tot_cfg) && ack_bits[base_q]) base_q++;
      while (deliver_q < int'(tot_cfg) && recv_bits[deliver_q]) begin
        deliver_q++;
        newly++;
      end
    end
    res.window_base     = 8'(base_q);
    res.window_end      = 8'(window_end_now());
    res.delivered_count = 8'(deliver_q);
    res.newly_delivered = 8'(newly);
    res.all_done        = base_q >= int'(tot_cfg);
    return res;
  endfunction

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (window_results_q.size() == 0) begin
      $error("result %h arrived with no request outstanding", got);
      fail_count++;
      return;
    end
    want = window_results_q.pop_front();
    cmp_field("accepted", 8'(want.accepted), 8'(got.accepted));
    cmp_field("window_base", want.window_base, got.window_base);
    cmp_field("window_end", want.window_end, got.window_end);
    cmp_field("delivered_count", want.delivered_count, got.delivered_count);
    cmp_field("newly_delivered", want.newly_delivered, got.newly_delivered);
    cmp_field("all_done", 8'(want.all_done), 8'(got.all_done));
    cmp_field("config_error", 8'(want.config_error), 8'(got.config_error));
  endtask

  // Mirror register writes at the same edge the block takes them
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      if (cfg_index_i == REG_WINDOW_SIZE) win_cfg = cfg_wdata_i;
      else tot_cfg = cfg_wdata_i;
    end
  end

  // Sender: bursts of requests separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        drv_res = track_window(cmd_e'(s_axis_tuser), s_axis_tdata[6:0],
                               outcome_e'(s_axis_tdata[8:7]));
        window_results_q.push_back(drv_res);
        n_requests++;
        n_rounds   += int'(s_axis_tuser == CMD_ROUND);
        n_accepted += int'(drv_res.accepted);
        n_cfg_err  += int'(drv_res.config_error);
        n_done     += int'(drv_res.all_done);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          drv_req = pend_q.pop_front();
          s_axis_tuser  <= drv_req.cmd;
          s_axis_tdata  <= {7'd0, drv_req.outc, drv_req.frame};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check results, stall on a changing pattern, hold off twice for a long stretch
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(result_t'(m_axis_tdata[34:0]));
        results_seen++;
        if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B) hold_left = LONG_HOLD;
      end
      rx_phase_cnt++;
      if (rx_phase_cnt >= 48) begin
        rx_phase_cnt = 0;
        rx_mode      = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: begin
            m_axis_tready <= 1'b1;
          end
          1: begin
            m_axis_tready <= $urandom_range(0, 1);
          end
          2: begin
            m_axis_tready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready <= rx_phase_cnt[0];
          end
        endcase
      end
    end
  end

  task automatic push_req(cmd_e cmd, int frame, outcome_e outc);
    frame_req_t rq;
    rq.cmd   = cmd;
    rq.frame = 7'(frame);
    rq.outc  = outc;
    pend_q.push_back(rq);
  endtask

  // Wait until every request is answered, then let the walker settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || s_axis_tvalid || window_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_window(int ws, int tot);
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 8'(ws));
    write_reg(REG_TOTAL_FRAMES, 8'(tot));
  endtask

  // Mostly reports on frames around the window, some rounds, some noise
  function automatic frame_req_t pick_req();
    frame_req_t rq;
    int         r;
    int         f;
    rq.cmd   = CMD_REPORT;
    rq.frame = 7'($urandom_range(0, 127));
    rq.outc  = outcome_e'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    if (r < 18) begin
      rq.cmd = CMD_ROUND;
    end else if (r < 90 && !cfg_invalid()) begin
      f = base_q + $urandom_range(0, int'(win_cfg) + 1);
      rq.frame = 7'((f > 127) ? 127 : f);
      r = $urandom_range(0, 99);
      if (r < 50)      rq.outc = OUTC_SUCCESS;
      else if (r < 72) rq.outc = OUTC_LOST;
      else if (r < 94) rq.outc = OUTC_ACK_LOST;
      else             rq.outc = OUTC_SPARE;
    end
    return rq;
  endfunction

  task automatic feed_random(int count);
    int i;
    for (i = 0; i < count; i++) begin
      while (pend_q.size() >= 2) @(negedge clk_i);
      pend_q.push_back(pick_req());
    end
  endtask

  initial begin
    int valid_items;
    int run_total;
    int ws;
    int tot;
    int n;
    int r;
    bit bad;

    valid_items = 0;
    run_total   = 16;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: window of 4 over 16 frames
    push_req(CMD_REPORT, 127, OUTC_SUCCESS);   // far outside the window
    push_req(CMD_REPORT, 0, OUTC_SUCCESS);
    push_req(CMD_REPORT, 1, OUTC_LOST);
    push_req(CMD_REPORT, 2, OUTC_ACK_LOST);
    push_req(CMD_REPORT, 3, OUTC_SPARE);
    push_req(CMD_REPORT, 0, OUTC_SUCCESS);     // already acknowledged
    push_req(CMD_REPORT, 4, OUTC_SUCCESS);     // at the window end, just outside
    push_req(CMD_ROUND, 85, OUTC_SPARE);
    push_req(CMD_REPORT, 1, OUTC_SUCCESS);
    push_req(CMD_REPORT, 2, OUTC_SUCCESS);     // ack was lost, so still open
    push_req(CMD_ROUND, 42, OUTC_SUCCESS);
    push_req(CMD_REPORT, 3, OUTC_SUCCESS);
    push_req(CMD_REPORT, 4, OUTC_SUCCESS);
    push_req(CMD_REPORT, 5, OUTC_ACK_LOST);
    push_req(CMD_ROUND, 0, OUTC_SUCCESS);

    // Invalid settings: zero window, window over total, total over range, zero total
    set_window(0, 16);
    push_req(CMD_REPORT, 6, OUTC_SUCCESS);
    push_req(CMD_ROUND, 0, OUTC_SUCCESS);
    set_window(20, 16);
    push_req(CMD_REPORT, 6, OUTC_SUCCESS);
    set_window(4, 200);
    push_req(CMD_ROUND, 0, OUTC_SUCCESS);
    set_window(4, 0);
    push_req(CMD_REPORT, 6, OUTC_SUCCESS);
    set_window(255, 255);
    push_req(CMD_ROUND, 127, OUTC_SPARE);

    // Total lowered below the base: nothing accepted, window end held at the base
    set_window(2, 3);
    push_req(CMD_REPORT, 5, OUTC_SUCCESS);
    push_req(CMD_ROUND, 0, OUTC_SUCCESS);

    // Widest window over the full sequence space
    set_window(128, 128);
    push_req(CMD_REPORT, 127, OUTC_ACK_LOST);
    push_req(CMD_REPORT, 64, OUTC_SUCCESS);
    push_req(CMD_ROUND, 0, OUTC_SUCCESS);

    while (valid_items < RANDOM_ITEMS) begin
      wait_idle();
      bad = 1'b0;
      r   = $urandom_range(0, 99);
      if (r < 8) begin
        bad = 1'b1;
        case ($urandom_range(0, 3))
          0: begin
            ws  = 0;
            tot = run_total;
          end
          1: begin
            ws  = 4;
            tot = 0;
          end
          2: begin
            tot = run_total;
            ws  = $urandom_range(tot + 1, 255);
          end
          default: begin
            tot = $urandom_range(MAX_SEQ + 1, 255);
            ws  = $urandom_range(1, MAX_SEQ);
          end
        endcase
      end else if (r < 15 && base_q > 1) begin
        tot = $urandom_range(1, base_q - 1);
        ws  = $urandom_range(1, tot);
      end else begin
        run_total = run_total + $urandom_range(0, 5);
        if (run_total > MAX_SEQ) run_total = MAX_SEQ;
        tot = run_total;
        r   = $urandom_range(0, 99);
        if (r < 10)      ws = 1;
        else if (r < 20) ws = tot;
        else             ws = $urandom_range(1, (tot < 16) ? tot : 16);
      end
      write_reg(REG_WINDOW_SIZE, 8'(ws));
      write_reg(REG_TOTAL_FRAMES, 8'(tot));
      n = bad ? $urandom_range(2, 6) : $urandom_range(15, 50);
      feed_random(n);
      if (!bad) valid_items += n;
    end

    wait_idle();
    $display("Run covered %0d requests (%0d rounds): %0d reports accepted, %0d setting errors,",
             n_requests, n_rounds, n_accepted, n_cfg_err);
    $display("%0d session-complete results, %0d results checked, %0d mismatches",
             n_done, results_seen, fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
